// File: rtl/core/kac_pkg.sv
// Shared types and constants for the keypad alarm controller.
package kac_pkg;

	// Item kinds
	localparam logic [1:0] MODE_KEY    = 2'd0;
	localparam logic [1:0] MODE_TICK   = 2'd1;
	localparam logic [1:0] MODE_MOTION = 2'd2;

	// Special key symbols
	localparam logic [3:0] KEY_STAR = 4'd10;
	localparam logic [3:0] KEY_HASH = 4'd11;

	// Phase codes
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_EXIT  = 3'd1;
	localparam logic [2:0] PH_CHIRP = 3'd2;
	localparam logic [2:0] PH_WATCH = 3'd3;
	localparam logic [2:0] PH_ENTRY = 3'd4;
	localparam logic [2:0] PH_ALARM = 3'd5;

	// Configuration register indexes and reset values
	localparam int         CFG_IDX_W     = 4;
	localparam logic [3:0] CFG_COUNTDOWN = 4'd0;
	localparam logic [3:0] CFG_CHIRP     = 4'd1;
	localparam logic [7:0] COUNTDOWN_RST = 8'd60;
	localparam logic [3:0] CHIRP_RST     = 4'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] key_code;
		logic       motion;
	} item_t;

	typedef struct packed {
		logic                 en;
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_wr_t;

	// Entry buffer command from the sequencer
	typedef struct packed {
		logic       clear;
		logic       push;
		logic       store;
		logic [3:0] sym;
	} entry_cmd_t;

	// Entry buffer status flags, taken from registered state
	typedef struct packed {
		logic full;
		logic len_ok;
		logic match;
	} entry_stat_t;

	// Result fields derived from the updated state
	typedef struct packed {
		logic       armed;
		logic       counting;
		logic [7:0] seconds_left;
		logic       red_lamp;
		logic       green_lamp;
		logic       buzzer;
		logic       keys_enabled;
	} result_t;

endpackage

// File: rtl/core/keypad_alarm_controller.sv
// Top level of the keypad alarm controller: input stage, sequencer, buffer, result stage.
// Path: an accepted item is registered in the input stage, and its result in the result register.
// Throughput: one item per cycle while out_ready does not hold the result stage.
// Reset: asynchronous active-low; disarmed idle, empty buffer, countdown 60, chirp 2.
// An empty input stage lets a new item enter while a result waits for out_ready.
module keypad_alarm_controller #(
	parameter int MAX_CODE_LEN = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [3:0]                    key_code,
	input  logic                          motion,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          armed,
	output logic                          counting,
	output logic [7:0]                    seconds_left,
	output logic [2:0]                    entered_length,
	output logic                          red_lamp,
	output logic                          green_lamp,
	output logic                          buzzer,
	output logic                          keys_enabled,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import kac_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        advance;
	entry_cmd_t  cmd;
	entry_stat_t stat;
	cfg_wr_t     cfg;
	result_t     res;
	logic [2:0]  len_n;
	logic        valid_s2;
	result_t     res_s2;
	logic [2:0]  len_s2;

	// Process the held item when the result stage is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign cfg_ready = 1'b1;
	assign cfg.en    = cfg_valid && cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode     <= mode;
			item_s1.key_code <= key_code;
			item_s1.motion   <= motion;
		end
	end

	kac_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.stat   (stat),
		.cfg    (cfg),
		.cmd    (cmd),
		.res    (res)
	);

	kac_entry #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_entry (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.entered_length (len_n)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
			len_s2 <= len_n;
		end
	end

	assign out_valid      = valid_s2;
	assign armed          = res_s2.armed;
	assign counting       = res_s2.counting;
	assign seconds_left   = res_s2.seconds_left;
	assign entered_length = len_s2;
	assign red_lamp       = res_s2.red_lamp;
	assign green_lamp     = res_s2.green_lamp;
	assign buzzer         = res_s2.buzzer;
	assign keys_enabled   = res_s2.keys_enabled;

`ifndef NO_ASSERTIONS
	// Lamps always show opposite states
	a_lamps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red_lamp != green_lamp))
		else $error("lamp outputs not complementary");

	// Locked keypad with buzzer means chirp: no countdown shown
	a_chirp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && buzzer && !keys_enabled) |-> (!counting && seconds_left == 8'd0))
		else $error("chirp result shows a countdown");

	// Exit countdown runs while still disarmed
	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && counting && !keys_enabled) |-> !armed)
		else $error("exit countdown reported as armed");

	// A stalled item stays in the input stage
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage item lost while stalled");
`endif

endmodule

// File: rtl/core/kac_entry.sv
// Entry buffer and stored passcode with the parallel symbol compare.
module kac_entry #(
	parameter int MAX_CODE_LEN = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kac_pkg::entry_cmd_t  cmd,
	output kac_pkg::entry_stat_t stat,
	output logic [2:0]           entered_length
);
	import kac_pkg::*;

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

	logic [3:0]       entry_q [MAX_CODE_LEN];
	logic [3:0]       code_q  [MAX_CODE_LEN];
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] code_len_q;
	logic [LEN_W-1:0] len_n;

	// Status flags and masked compare over the held symbols
	always_comb begin
		logic eq;
		eq = (len_q == code_len_q);
		for (int i = 0; i < MAX_CODE_LEN; i++) begin
			if ((LEN_W'(i) < len_q) && (entry_q[i] != code_q[i])) begin
				eq = 1'b0;
			end
		end
		stat.full   = (len_q == LEN_W'(MAX_CODE_LEN));
		stat.len_ok = (len_q == LEN_W'(4)) || (len_q == LEN_W'(MAX_CODE_LEN));
		stat.match  = eq;
	end

	// Length after this transaction
	always_comb begin
		if (cmd.clear) begin
			len_n = '0;
		end else if (cmd.push) begin
			len_n = len_q + 1'b1;
		end else begin
			len_n = len_q;
		end
	end

	assign entered_length = len_n[2:0];

	// Update buffer and passcode store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			code_len_q <= '0;
			for (int i = 0; i < MAX_CODE_LEN; i++) begin
				entry_q[i] <= '0;
				code_q[i]  <= '0;
			end
		end else begin
			if (cmd.store) begin
				code_len_q <= len_q;
				for (int i = 0; i < MAX_CODE_LEN; i++) begin
					code_q[i] <= entry_q[i];
				end
			end
			if (cmd.clear) begin
				for (int i = 0; i < MAX_CODE_LEN; i++) begin
					entry_q[i] <= '0;
				end
			end else if (cmd.push) begin
				for (int i = 0; i < MAX_CODE_LEN; i++) begin
					if (len_q == LEN_W'(i)) begin
						entry_q[i] <= cmd.sym;
					end
				end
			end
			len_q <= len_n;
		end
	end

endmodule

// File: rtl/core/kac_seq.sv
// Arming sequencer: phase, countdown and chirp timers, configuration registers.
module kac_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  kac_pkg::item_t       item,
	input  kac_pkg::entry_stat_t stat,
	input  kac_pkg::cfg_wr_t     cfg,
	output kac_pkg::entry_cmd_t  cmd,
	output kac_pkg::result_t     res
);
	import kac_pkg::*;

	logic [2:0] phase_q, phase_n;
	logic [7:0] count_q, count_n;
	logic [3:0] chirp_q, chirp_n;
	logic       mot_en_q, mot_en_n;
	logic [7:0] cd_cfg_q;
	logic [3:0] chirp_cfg_q;
	entry_cmd_t cmd_n;

	// Next state for one transaction
	always_comb begin
		phase_n  = phase_q;
		count_n  = count_q;
		chirp_n  = chirp_q;
		mot_en_n = mot_en_q;
		cmd_n    = '0;
		cmd_n.sym = item.key_code;
		case (item.mode)
			MODE_KEY: begin
				if (phase_q != PH_EXIT && phase_q != PH_CHIRP) begin
					if (item.key_code == KEY_STAR) begin
						cmd_n.clear = 1'b1;
					end else if (item.key_code == KEY_HASH) begin
						if (stat.len_ok) begin
							if (phase_q == PH_IDLE) begin
								cmd_n.store = 1'b1;
								cmd_n.clear = 1'b1;
								count_n     = cd_cfg_q;
								phase_n     = PH_EXIT;
							end else if (stat.match) begin
								cmd_n.clear = 1'b1;
								count_n     = cd_cfg_q;
								mot_en_n    = 1'b0;
								phase_n     = PH_IDLE;
							end
						end else begin
							cmd_n.clear = 1'b1;
						end
					end else if (!stat.full) begin
						cmd_n.push = 1'b1;
					end else begin
						cmd_n.clear = 1'b1;
					end
				end
			end
			MODE_TICK: begin
				case (phase_q)
					PH_EXIT: begin
						if (count_q <= 8'd1) begin
							count_n = '0;
							if (chirp_cfg_q == 4'd0) begin
								phase_n  = PH_WATCH;
								mot_en_n = 1'b1;
								count_n  = cd_cfg_q;
							end else begin
								chirp_n = chirp_cfg_q;
								phase_n = PH_CHIRP;
							end
						end else begin
							count_n = count_q - 8'd1;
						end
					end
					PH_CHIRP: begin
						if (chirp_q <= 4'd1) begin
							chirp_n  = '0;
							phase_n  = PH_WATCH;
							mot_en_n = 1'b1;
							count_n  = cd_cfg_q;
						end else begin
							chirp_n = chirp_q - 4'd1;
						end
					end
					PH_ENTRY: begin
						if (count_q <= 8'd1) begin
							count_n  = cd_cfg_q;
							mot_en_n = 1'b0;
							phase_n  = PH_ALARM;
						end else begin
							count_n = count_q - 8'd1;
						end
					end
					default: begin
					end
				endcase
			end
			MODE_MOTION: begin
				if (phase_q == PH_WATCH && mot_en_q && item.motion) begin
					count_n = cd_cfg_q;
					phase_n = PH_ENTRY;
				end
			end
			default: begin
			end
		endcase
	end

	// Drive the buffer only on a live transaction
	assign cmd = go ? cmd_n : '0;

	// Derive outputs from the updated state
	always_comb begin
		res.armed        = (phase_n == PH_CHIRP) || (phase_n == PH_WATCH) ||
		                   (phase_n == PH_ENTRY) || (phase_n == PH_ALARM);
		res.counting     = (phase_n == PH_EXIT) || (phase_n == PH_ENTRY);
		res.seconds_left = count_n;
		res.red_lamp     = res.armed;
		res.green_lamp   = !res.armed;
		res.buzzer       = (phase_n == PH_CHIRP) || (phase_n == PH_ALARM);
		res.keys_enabled = !((phase_n == PH_EXIT) || (phase_n == PH_CHIRP));
	end

	// Hold or advance the control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= COUNTDOWN_RST;
			chirp_q  <= '0;
			mot_en_q <= 1'b0;
		end else if (go) begin
			phase_q  <= phase_n;
			count_q  <= count_n;
			chirp_q  <= chirp_n;
			mot_en_q <= mot_en_n;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_cfg_q    <= COUNTDOWN_RST;
			chirp_cfg_q <= CHIRP_RST;
		end else if (cfg.en) begin
			case (cfg.index)
				CFG_COUNTDOWN: cd_cfg_q    <= cfg.data;
				CFG_CHIRP:     chirp_cfg_q <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

endmodule
